@@ rtl/gbn_pkg.sv @@
// Shared types, constants and checksum helper for the Go-Back-N sender window.
`default_nettype none
package gbn_pkg;

    localparam int COUNT_BITS = 32;
    localparam int SEQ_BITS   = 8;
    localparam int LEN_BITS   = 32;
    localparam int SEG_BITS   = 16;
    localparam int WIN_BITS   = 8;
    localparam int TMO_BITS   = 32;
    localparam int WORD_BITS  = 16;

    localparam int FIFO_DEPTH     = 2;
    localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

    localparam int DIV_CNT_BITS = $clog2(LEN_BITS);

    localparam logic [WIN_BITS-1:0] WINDOW_SIZE_RST   = 8'd1;
    localparam logic [TMO_BITS-1:0] TIMEOUT_TICKS_RST = 32'd500;
    localparam logic [SEG_BITS-1:0] SEGMENT_BYTES_RST = 16'd10240;

    localparam logic [WORD_BITS-1:0] CSUM_GOOD = 16'hffff;

    // Configuration register indexes
    localparam logic [1:0] CFG_WINDOW_SIZE   = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd1;
    localparam logic [1:0] CFG_SEGMENT_BYTES = 2'd2;

    localparam logic RES_DATA = 1'b0;
    localparam logic RES_DONE = 1'b1;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_ACK   = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_POLL  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN,
        S_MUL
    } t_back_state;

    typedef struct packed {
        t_action             action;
        logic [LEN_BITS-1:0] len;
        logic [SEQ_BITS-1:0] ack;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_status;

    typedef struct packed {
        logic        valid;
        logic [1:0]  index;
        logic [31:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic                 kind;
        logic [7:0]           seq;
        logic [SEG_BITS-1:0]  len;
        logic [31:0]          offset;
        logic [WORD_BITS-1:0] csum;
        logic                 last;
    } t_result;

    // Ones'-complement add with end-around carry
    function automatic logic [WORD_BITS-1:0] oc_add(input logic [WORD_BITS-1:0] a,
                                                    input logic [WORD_BITS-1:0] b);
        logic [WORD_BITS:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[WORD_BITS-1:0] + {{(WORD_BITS-1){1'b0}}, t[WORD_BITS]};
    endfunction

endpackage
`default_nettype wire

@@ rtl/gbn_front.sv @@
// Front end: accepts input beats, checks ack header checksums, forms queue commands.
`default_nettype none
module gbn_front (
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [1:0]                    i_action,
    input  wire logic [gbn_pkg::LEN_BITS-1:0]  i_message_length,
    input  wire logic [15:0]                   i_hdr_checksum,
    input  wire logic [15:0]                   i_hdr_length,
    input  wire logic [7:0]                    i_hdr_seq,
    input  wire logic [7:0]                    i_ack_number,
    input  wire logic [7:0]                    i_hdr_flag,
    input  wire logic [7:0]                    i_hdr_spare,
    input  wire gbn_pkg::t_fifo_status         i_fifo,
    output logic                               o_push,
    output gbn_pkg::t_cmd                      o_cmd
);

    gbn_pkg::t_action                  w_act;
    logic [gbn_pkg::WORD_BITS-1:0]     w_sum;
    logic                              w_keep;

    assign w_act = gbn_pkg::t_action'(i_action);

    // fold of the four header words; a good header sums to all ones
    assign w_sum = gbn_pkg::oc_add(
                       gbn_pkg::oc_add(gbn_pkg::oc_add(i_hdr_checksum, i_hdr_length),
                                       {i_ack_number, i_hdr_seq}),
                       {i_hdr_spare, i_hdr_flag});

    always_comb begin
        unique case (w_act)
            gbn_pkg::ACT_ACK: w_keep = (w_sum == gbn_pkg::CSUM_GOOD);
            default:          w_keep = 1'b1;
        endcase
    end

    assign o_ready       = !i_fifo.full;
    assign o_push        = i_valid && !i_fifo.full && w_keep;
    assign o_cmd.action  = w_act;
    assign o_cmd.len     = i_message_length;
    assign o_cmd.ack     = i_ack_number;

endmodule
`default_nettype wire

@@ rtl/gbn_fifo.sv @@
// Short command queue between front end and back end.
`default_nettype none
module gbn_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire gbn_pkg::t_cmd  i_cmd,
    input  wire logic           i_pop,
    output gbn_pkg::t_cmd       o_head,
    output gbn_pkg::t_fifo_status o_status
);

    gbn_pkg::t_cmd                         r_mem [gbn_pkg::FIFO_DEPTH];
    logic [gbn_pkg::FIFO_PTR_BITS-1:0]     r_wr_ptr;
    logic [gbn_pkg::FIFO_PTR_BITS-1:0]     r_rd_ptr;
    logic [gbn_pkg::FIFO_CNT_BITS-1:0]     r_count;
    logic [gbn_pkg::FIFO_PTR_BITS-1:0]     n_wr_ptr;
    logic [gbn_pkg::FIFO_PTR_BITS-1:0]     n_rd_ptr;
    logic [gbn_pkg::FIFO_CNT_BITS-1:0]     n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == gbn_pkg::FIFO_CNT_BITS'(gbn_pkg::FIFO_DEPTH));

endmodule
`default_nettype wire

@@ rtl/gbn_back.sv @@
// Back end: window state, start divider, poll offset multiply and result register.
`default_nettype none
module gbn_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire gbn_pkg::t_cfg_wr       i_cfg,
    input  wire gbn_pkg::t_cmd          i_head,
    input  wire gbn_pkg::t_fifo_status  i_fifo,
    output logic                        o_pop,
    input  wire logic                   i_out_ready,
    output logic                        o_out_valid,
    output gbn_pkg::t_result            o_out
);

    localparam int CB = gbn_pkg::COUNT_BITS;
    localparam int SB = gbn_pkg::SEG_BITS;
    localparam int LB = gbn_pkg::LEN_BITS;

    // configuration
    logic [gbn_pkg::WIN_BITS-1:0]  r_window_size;
    logic [gbn_pkg::TMO_BITS-1:0]  r_timeout;
    logic [SB-1:0]                 r_seg_bytes;

    gbn_pkg::t_back_state          r_state, n_state;
    logic                          r_active, n_active;
    logic [CB-1:0]                 r_count, n_count;
    logic [CB-1:0]                 r_base, n_base;
    logic [CB-1:0]                 r_wend, n_wend;
    logic [CB-1:0]                 r_next, n_next;
    logic [SB-1:0]                 r_last_len, n_last_len;
    logic [31:0]                   r_elapsed, n_elapsed;
    logic [gbn_pkg::DIV_CNT_BITS-1:0] r_div_cnt, n_div_cnt;
    logic [LB-1:0]                 r_div_q, n_div_q;
    logic [SB-1:0]                 r_div_r, n_div_r;
    logic [SB-1:0]                 r_p_len, n_p_len;
    logic [7:0]                    r_p_seq, n_p_seq;
    logic                          r_p_last, n_p_last;
    logic [31:0]                   r_prod, n_prod;
    logic                          r_out_valid, n_out_valid;
    gbn_pkg::t_result              r_out, n_out;

    logic [SB-1:0]                 w_seg;
    logic [CB-1:0]                 w_win;
    logic                          w_out_free;
    logic [gbn_pkg::SEQ_BITS-1:0]  w_step;
    logic [CB:0]                   w_base_sum, w_wend_sum;
    logic [CB-1:0]                 w_base_cl, w_wend_cl;
    logic                          w_ack_done;
    logic [31:0]                   w_el_inc;
    logic [SB:0]                   w_trial;
    logic                          w_ge;
    logic [CB-1:0]                 w_cnt;
    logic                          w_rem_nz;
    logic [CB+SB-1:0]              w_prod_full;
    logic                          w_last;

    assign w_seg      = (r_seg_bytes == '0) ? SB'(1) : r_seg_bytes;
    assign w_win      = (r_window_size == '0) ? CB'(1) : CB'(r_window_size);
    assign w_out_free = !r_out_valid || i_out_ready;

    // cumulative ack: distance from base modulo the sequence space, clamped at the count
    assign w_step     = i_head.ack[gbn_pkg::SEQ_BITS-1:0] - r_base[gbn_pkg::SEQ_BITS-1:0];
    assign w_base_sum = {1'b0, r_base} + (CB+1)'(w_step);
    assign w_wend_sum = {1'b0, r_wend} + (CB+1)'(w_step);
    assign w_base_cl  = (w_base_sum > {1'b0, r_count}) ? r_count : w_base_sum[CB-1:0];
    assign w_wend_cl  = (w_wend_sum > {1'b0, r_count}) ? r_count : w_wend_sum[CB-1:0];
    assign w_ack_done = (w_base_cl >= r_count);

    assign w_el_inc   = (r_elapsed == '1) ? r_elapsed : r_elapsed + 32'd1;

    // restoring divider, one quotient bit per cycle
    assign w_trial    = {r_div_r, r_div_q[LB-1]};
    assign w_ge       = (w_trial >= {1'b0, w_seg});
    assign w_rem_nz   = (r_div_r != '0);
    assign w_cnt      = CB'(r_div_q) + CB'(w_rem_nz);

    assign w_prod_full = r_next * w_seg;
    assign w_last      = (r_next == r_count - CB'(1));

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_count     = r_count;
        n_base      = r_base;
        n_wend      = r_wend;
        n_next      = r_next;
        n_last_len  = r_last_len;
        n_elapsed   = r_elapsed;
        n_div_cnt   = r_div_cnt;
        n_div_q     = r_div_q;
        n_div_r     = r_div_r;
        n_p_len     = r_p_len;
        n_p_seq     = r_p_seq;
        n_p_last    = r_p_last;
        n_prod      = r_prod;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_pop       = 1'b0;

        unique case (r_state)
            gbn_pkg::S_IDLE: begin
                if (!i_fifo.empty) begin
                    unique case (i_head.action)
                        gbn_pkg::ACT_START: begin
                            o_pop     = 1'b1;
                            n_div_q   = i_head.len;
                            n_div_r   = '0;
                            n_div_cnt = '0;
                            n_state   = gbn_pkg::S_DIV;
                        end
                        gbn_pkg::ACT_ACK: begin
                            if (!r_active || w_step == '0) begin
                                o_pop = 1'b1;
                            end else if (!w_ack_done || w_out_free) begin
                                o_pop  = 1'b1;
                                n_base = w_base_cl;
                                n_wend = w_wend_cl;
                                if (w_ack_done) begin
                                    n_active    = 1'b0;
                                    n_out_valid = 1'b1;
                                    n_out       = '0;
                                    n_out.kind  = gbn_pkg::RES_DONE;
                                end
                            end
                        end
                        gbn_pkg::ACT_TICK: begin
                            o_pop = 1'b1;
                            if (r_active) begin
                                n_elapsed = w_el_inc;
                                if (r_next >= r_wend && w_el_inc > r_timeout) begin
                                    n_next    = r_base;
                                    n_elapsed = '0;
                                end
                            end
                        end
                        gbn_pkg::ACT_POLL: begin
                            o_pop = 1'b1;
                            if (r_active && r_next < r_wend) begin
                                n_p_last = w_last;
                                n_p_len  = w_last ? r_last_len : w_seg;
                                n_p_seq  = r_next[7:0];
                                n_prod   = w_prod_full[31:0];
                                n_state  = gbn_pkg::S_MUL;
                            end
                        end
                    endcase
                end
            end
            gbn_pkg::S_DIV: begin
                n_div_r   = w_ge ? SB'(w_trial - {1'b0, w_seg}) : w_trial[SB-1:0];
                n_div_q   = {r_div_q[LB-2:0], w_ge};
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == gbn_pkg::DIV_CNT_BITS'(LB - 1)) begin
                    n_state = gbn_pkg::S_FIN;
                end
            end
            gbn_pkg::S_FIN: begin
                if (w_cnt != '0 || w_out_free) begin
                    n_count    = w_cnt;
                    n_base     = '0;
                    n_next     = '0;
                    n_elapsed  = '0;
                    n_wend     = (w_cnt < w_win) ? w_cnt : w_win;
                    n_last_len = (w_cnt == '0) ? '0 : (w_rem_nz ? r_div_r : w_seg);
                    n_active   = (w_cnt != '0);
                    n_state    = gbn_pkg::S_IDLE;
                    if (w_cnt == '0) begin
                        n_out_valid = 1'b1;
                        n_out       = '0;
                        n_out.kind  = gbn_pkg::RES_DONE;
                    end
                end
            end
            gbn_pkg::S_MUL: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out.kind  = gbn_pkg::RES_DATA;
                    n_out.seq   = r_p_seq;
                    n_out.len   = r_p_len;
                    n_out.offset = r_prod;
                    n_out.csum  = ~gbn_pkg::oc_add(r_p_len, {8'd0, r_p_seq});
                    n_out.last  = r_p_last;
                    n_next      = r_next + CB'(1);
                    n_elapsed   = '0;
                    n_state     = gbn_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gbn_pkg::S_IDLE;
            r_active    <= 1'b0;
            r_count     <= '0;
            r_base      <= '0;
            r_wend      <= '0;
            r_next      <= '0;
            r_last_len  <= '0;
            r_elapsed   <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_count     <= n_count;
            r_base      <= n_base;
            r_wend      <= n_wend;
            r_next      <= n_next;
            r_last_len  <= n_last_len;
            r_elapsed   <= n_elapsed;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div_q  <= n_div_q;
        r_div_r  <= n_div_r;
        r_p_len  <= n_p_len;
        r_p_seq  <= n_p_seq;
        r_p_last <= n_p_last;
        r_prod   <= n_prod;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= gbn_pkg::WINDOW_SIZE_RST;
            r_timeout     <= gbn_pkg::TIMEOUT_TICKS_RST;
            r_seg_bytes   <= gbn_pkg::SEGMENT_BYTES_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                gbn_pkg::CFG_WINDOW_SIZE:   r_window_size <= i_cfg.data[gbn_pkg::WIN_BITS-1:0];
                gbn_pkg::CFG_TIMEOUT_TICKS: r_timeout     <= i_cfg.data[gbn_pkg::TMO_BITS-1:0];
                gbn_pkg::CFG_SEGMENT_BYTES: r_seg_bytes   <= i_cfg.data[SB-1:0];
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

@@ rtl/go_back_n_sender_window.sv @@
// Go-Back-N sender window: top level with front end, command queue and back end.
// A poll beat's descriptor passes the queue, the offset multiply register and the result
// register, an ack's done beat the queue and the result register; the back end takes one
// command at a time. A start runs the restoring divider, one quotient bit per cycle.
// The 2-entry queue takes up to two beats while the back end divides or the result stalls.
// Reset (synchronous, active low): window closed, queue empty, registers to defaults.
`default_nettype none
module go_back_n_sender_window (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input beats
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [31:0] i_message_length,
    input  wire logic [15:0] i_hdr_checksum,
    input  wire logic [15:0] i_hdr_length,
    input  wire logic [7:0]  i_hdr_seq,
    input  wire logic [7:0]  i_ack_number,
    input  wire logic [7:0]  i_hdr_flag,
    input  wire logic [7:0]  i_hdr_spare,
    // result beats
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_result_kind,
    output logic [7:0]       o_seq_number,
    output logic [15:0]      o_segment_length,
    output logic [31:0]      o_byte_offset,
    output logic [15:0]      o_header_checksum,
    output logic             o_last_segment,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    gbn_pkg::t_cmd          w_push_cmd;
    gbn_pkg::t_cmd          w_head;
    gbn_pkg::t_fifo_status  w_fifo_st;
    gbn_pkg::t_cfg_wr       w_cfg;
    gbn_pkg::t_result       w_out;
    logic                   w_push;
    logic                   w_pop;

    // Config writes always land at once; the user must issue them only while idle, the block does not enforce it.
    assign o_cfg_ready = 1'b1;
    assign w_cfg.valid = i_cfg_valid;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    // Front end: bad-checksum acks are accepted and dropped here, they never
    // reach the queue.
    gbn_front u_front (
        .i_valid          (i_in_valid),
        .o_ready          (o_in_ready),
        .i_action         (i_action),
        .i_message_length (i_message_length),
        .i_hdr_checksum   (i_hdr_checksum),
        .i_hdr_length     (i_hdr_length),
        .i_hdr_seq        (i_hdr_seq),
        .i_ack_number     (i_ack_number),
        .i_hdr_flag       (i_hdr_flag),
        .i_hdr_spare      (i_hdr_spare),
        .i_fifo           (w_fifo_st),
        .o_push           (w_push),
        .o_cmd            (w_push_cmd)
    );

    gbn_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_fifo_st)
    );

    // Back end: holds the window state; an ack that completes the transfer is popped only
    // once its done result has a free output register; starts and polls wait for it later.
    gbn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_head      (w_head),
        .i_fifo      (w_fifo_st),
        .o_pop       (w_pop),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (w_out)
    );

    assign o_result_kind     = w_out.kind;
    assign o_seq_number      = w_out.seq;
    assign o_segment_length  = w_out.len;
    assign o_byte_offset     = w_out.offset;
    assign o_header_checksum = w_out.csum;
    assign o_last_segment    = w_out.last;

    // back end never pops an empty queue
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_fifo_st.empty)
        else $error("pop of empty command queue");

    // a done beat carries nothing but its kind
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind) |->
            (o_seq_number == 8'd0 && o_segment_length == 16'd0 &&
             o_byte_offset == 32'd0 && o_header_checksum == 16'd0 && !o_last_segment))
        else $error("done beat with non-zero fields");

    // every data segment has payload
    a_seg_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_result_kind) |-> (o_segment_length != 16'd0))
        else $error("data segment of zero length");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

endmodule
`default_nettype wire

@@ tb/sv/gbn_window_checker.sv @@
// Scoreboard for the Go-Back-N sender window: predicts every result beat and compares it.
`timescale 1ns / 100ps
module gbn_window_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_message_length,
    input  logic [15:0] i_hdr_checksum,
    input  logic [15:0] i_hdr_length,
    input  logic [7:0]  i_hdr_seq,
    input  logic [7:0]  i_ack_number,
    input  logic [7:0]  i_hdr_flag,
    input  logic [7:0]  i_hdr_spare,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_result_kind,
    input  logic [7:0]  i_seq_number,
    input  logic [15:0] i_segment_length,
    input  logic [31:0] i_byte_offset,
    input  logic [15:0] i_header_checksum,
    input  logic        i_last_segment,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_done_count
);
    import gbn_pkg::*;

    // shadow registers
    logic [7:0]  window_reg;
    logic [31:0] timeout_reg;
    logic [15:0] segsize_reg;

    // shadow window state
    logic        xfer_active;
    logic [63:0] seg_total;
    logic [63:0] base_idx;
    logic [63:0] win_end;
    logic [63:0] next_idx;
    logic [15:0] tail_len;
    logic [31:0] idle_ticks;

    t_result pending_results[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_done_count = 0;
    end

    // inverted end-around-carry sum, w0 in the low word
    function automatic logic [15:0] csum_of(input logic [63:0] words);
        logic [16:0] s;
        s = '0;
        for (int k = 0; k < 4; k++) begin
            s = s + {1'b0, words[16*k +: 16]};
            if (s[16]) s = {1'b0, s[15:0]} + 17'd1;
        end
        return ~s[15:0];
    endfunction

    task automatic push_done();
        t_result r;
        r = '0;
        r.kind = RES_DONE;
        pending_results.push_back(r);
    endtask

    task automatic advance_window(input logic [1:0] act, input logic [31:0] msg_len,
                                  input logic [15:0] csum, input logic [15:0] hlen,
                                  input logic [7:0] hseq, input logic [7:0] ackn,
                                  input logic [7:0] hflag, input logic [7:0] hspare);
        logic [63:0] seg;
        logic [63:0] win;
        logic [63:0] cnt;
        logic [63:0] len;
        logic [63:0] prod;
        logic [7:0]  step;
        logic [15:0] dlen;
        logic        fin;
        t_result     r;
        seg = (segsize_reg == 16'd0) ? 64'd1 : {48'd0, segsize_reg};
        win = (window_reg == 8'd0) ? 64'd1 : {56'd0, window_reg};
        if (!xfer_active && act != ACT_START) return;
        case (act)
            ACT_START: begin
                len        = {32'd0, msg_len};
                cnt        = (len + seg - 64'd1) / seg;
                seg_total  = cnt;
                base_idx   = '0;
                next_idx   = '0;
                idle_ticks = '0;
                win_end    = (cnt < win) ? cnt : win;
                prod       = len - seg * (cnt - 64'd1);
                tail_len   = (cnt != 0) ? prod[15:0] : 16'd0;
                xfer_active = (cnt != 0);
                if (cnt == 0) push_done();
            end
            ACT_ACK: begin
                // header must fold to zero, duplicates of the base are dropped
                if (csum_of({hspare, hflag, ackn, hseq, hlen, csum}) != 16'd0) return;
                if (ackn == base_idx[7:0]) return;
                step     = ackn - base_idx[7:0];
                base_idx = base_idx + {56'd0, step};
                if (base_idx > seg_total) base_idx = seg_total;
                win_end  = win_end + {56'd0, step};
                if (win_end > seg_total) win_end = seg_total;
                if (base_idx >= seg_total) begin
                    xfer_active = 1'b0;
                    push_done();
                end
            end
            ACT_TICK: begin
                if (idle_ticks != 32'hffff_ffff) idle_ticks = idle_ticks + 32'd1;
                if (next_idx >= win_end && idle_ticks > timeout_reg) begin
                    next_idx   = base_idx;
                    idle_ticks = '0;
                end
            end
            default: begin
                if (next_idx < win_end) begin
                    fin      = (next_idx == seg_total - 64'd1);
                    dlen     = fin ? tail_len : seg[15:0];
                    prod     = next_idx * seg;
                    r.kind   = RES_DATA;
                    r.seq    = next_idx[7:0];
                    r.len    = dlen;
                    r.offset = prod[31:0];
                    r.csum   = csum_of({16'd0, 8'd0, next_idx[7:0], dlen, 16'd0});
                    r.last   = fin;
                    pending_results.push_back(r);
                    next_idx   = next_idx + 64'd1;
                    idle_ticks = '0;
                end
            end
        endcase
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (pending_results.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("%0t: result beat with nothing expected: kind %0d seq %0d len %0d",
                         $time, got.kind, got.seq, got.len);
            return;
        end
        want = pending_results.pop_front();
        o_checked++;
        if (want.kind == RES_DONE) o_done_count++;
        if (got.kind !== want.kind || got.seq !== want.seq || got.len !== want.len ||
            got.offset !== want.offset || got.csum !== want.csum ||
            got.last !== want.last) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("%0t: mismatch, expected kind %0d seq %0d len %0d off %h csum %h last %0d",
                         $time, want.kind, want.seq, want.len, want.offset, want.csum,
                         want.last);
                $display("%0t:           got      kind %0d seq %0d len %0d off %h csum %h last %0d",
                         $time, got.kind, got.seq, got.len, got.offset, got.csum, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            window_reg  = WINDOW_SIZE_RST;
            timeout_reg = TIMEOUT_TICKS_RST;
            segsize_reg = SEGMENT_BYTES_RST;
            xfer_active = 1'b0;
            seg_total   = '0;
            base_idx    = '0;
            win_end     = '0;
            next_idx    = '0;
            tail_len    = '0;
            idle_ticks  = '0;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WINDOW_SIZE:   window_reg  = i_cfg_data[7:0];
                    CFG_TIMEOUT_TICKS: timeout_reg = i_cfg_data;
                    CFG_SEGMENT_BYTES: segsize_reg = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                advance_window(i_action, i_message_length, i_hdr_checksum, i_hdr_length,
                               i_hdr_seq, i_ack_number, i_hdr_flag, i_hdr_spare);
            if (i_out_valid && i_out_ready)
                check_result('{kind: i_result_kind, seq: i_seq_number,
                               len: i_segment_length, offset: i_byte_offset,
                               csum: i_header_checksum, last: i_last_segment});
        end
        o_pending = pending_results.size();
    end

endmodule

@@ tb/sv/tb_go_back_n_sender_window.sv @@
// Testbench top for the Go-Back-N sender window: stimulus, output back-pressure and verdict.
`timescale 1ns / 100ps
module tb_go_back_n_sender_window;
    import gbn_pkg::*;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int HOLD_CYCLES  = 300;   // long output stall, fills the command queue
    localparam int DRAIN_CYCLES = 120;   // covers up to three queued starts in the divider
    localparam int BEATS_PER_PHASE = 112;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;

    // input channel
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [1:0]  act       = ACT_TICK;
    logic [31:0] msg_len   = '0;
    logic [15:0] hdr_csum  = '0;
    logic [15:0] hdr_len   = '0;
    logic [7:0]  hdr_seq   = '0;
    logic [7:0]  ack_num   = '0;
    logic [7:0]  hdr_flag  = '0;
    logic [7:0]  hdr_spare = '0;

    // result channel
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        res_kind;
    logic [7:0]  res_seq;
    logic [15:0] res_len;
    logic [31:0] res_offset;
    logic [15:0] res_csum;
    logic        res_last;

    // register write channel
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int checked;
    int done_count;

    int cycles      = 0;
    int beats_live  = 0;
    int transfers   = 0;
    int settings    = 0;
    int long_holds  = 0;
    bit burst_mode  = 1'b0;
    bit hold_req    = 1'b0;

    // rough view of the window, only used to steer the ack numbers
    int     seg_now = 10240;
    int     win_now = 1;
    longint tb_count = 0;
    longint tb_base  = 0;
    longint tb_next  = 0;
    bit     tb_live  = 1'b0;

    go_back_n_sender_window i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_action          (act),
        .i_message_length  (msg_len),
        .i_hdr_checksum    (hdr_csum),
        .i_hdr_length      (hdr_len),
        .i_hdr_seq         (hdr_seq),
        .i_ack_number      (ack_num),
        .i_hdr_flag        (hdr_flag),
        .i_hdr_spare       (hdr_spare),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_result_kind     (res_kind),
        .o_seq_number      (res_seq),
        .o_segment_length  (res_len),
        .o_byte_offset     (res_offset),
        .o_header_checksum (res_csum),
        .o_last_segment    (res_last),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    gbn_window_checker i_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_action          (act),
        .i_message_length  (msg_len),
        .i_hdr_checksum    (hdr_csum),
        .i_hdr_length      (hdr_len),
        .i_hdr_seq         (hdr_seq),
        .i_ack_number      (ack_num),
        .i_hdr_flag        (hdr_flag),
        .i_hdr_spare       (hdr_spare),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_result_kind     (res_kind),
        .i_seq_number      (res_seq),
        .i_segment_length  (res_len),
        .i_byte_offset     (res_offset),
        .i_header_checksum (res_csum),
        .i_last_segment    (res_last),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_checked         (checked),
        .o_done_count      (done_count)
    );

    always #1 clk = ~clk;

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // checksum word that makes an ack header fold to zero
    function automatic logic [15:0] ack_header_csum(input logic [47:0] words);
        logic [16:0] s;
        s = '0;
        for (int k = 0; k < 3; k++) begin
            s = s + {1'b0, words[16*k +: 16]};
            if (s[16]) s = {1'b0, s[15:0]} + 17'd1;
        end
        return ~s[15:0];
    endfunction

    // mostly short transfers of a few segments, now and then the edges
    function automatic logic [31:0] pick_length();
        int          r;
        logic [31:0] k;
        logic [31:0] seg;
        logic [31:0] trim;
        r    = $urandom_range(0, 99);
        k    = $urandom_range(1, 12);
        seg  = seg_now;
        trim = $urandom_range(0, seg_now - 1);
        if (r < 5) return 32'd0;
        if (r < 8) return 32'hffff_ffff;
        if (r < 15) return k * seg;
        return k * seg - trim;
    endfunction

    // one input beat: random gap, then valid held until the handshake
    task automatic drive_beat(input t_action a, input logic [31:0] len_word,
                              input logic [15:0] csum, input logic [15:0] hlen,
                              input logic [7:0] hseq, input logic [7:0] ackn,
                              input logic [7:0] hflag, input logic [7:0] hspare);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        act       <= a;
        msg_len   <= len_word;
        hdr_csum  <= csum;
        hdr_len   <= hlen;
        hdr_seq   <= hseq;
        ack_num   <= ackn;
        hdr_flag  <= hflag;
        hdr_spare <= hspare;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // fills the unused words at random; good selects a folding ack header
    task automatic offer_beat(input t_action a, input logic [31:0] msg,
                              input logic [7:0] ackn, input bit good);
        logic [15:0] hlen;
        logic [15:0] csum;
        logic [7:0]  hseq;
        logic [7:0]  hflag;
        logic [7:0]  hspare;
        logic [31:0] rnd;
        logic [31:0] len_word;
        logic [7:0]  step;
        rnd    = $urandom;
        hlen   = rnd[15:0];
        hseq   = rnd[23:16];
        hflag  = rnd[31:24];
        rnd    = $urandom;
        hspare = rnd[7:0];
        csum   = ack_header_csum({hspare, hflag, ackn, hseq, hlen});
        if (!good) csum = csum ^ (16'd1 << rnd[11:8]);
        len_word = (a == ACT_START) ? msg : $urandom;
        if (a == ACT_START || tb_live) beats_live++;
        drive_beat(a, len_word, csum, hlen, hseq, ackn, hflag, hspare);
        if (a == ACT_START) begin
            tb_count = (longint'(msg) + seg_now - 1) / seg_now;
            tb_base  = 0;
            tb_next  = 0;
            tb_live  = (tb_count != 0);
        end else if (tb_live && a == ACT_ACK && good) begin
            step    = ackn - tb_base[7:0];
            tb_base = tb_base + step;
            if (tb_next < tb_base) tb_next = tb_base;
            if (tb_base >= tb_count) tb_live = 1'b0;
        end else if (tb_live && a == ACT_POLL) begin
            if (tb_next < tb_count && tb_next < tb_base + win_now) tb_next++;
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // spare upper bits carry noise, the block keeps only the register width
    task automatic configure(input logic [7:0] win, input logic [31:0] tmo,
                             input logic [15:0] seg);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(CFG_WINDOW_SIZE, {junk[31:8], win});
        write_reg(CFG_TIMEOUT_TICKS, tmo);
        junk = $urandom;
        write_reg(CFG_SEGMENT_BYTES, {junk[31:16], seg});
        cfg_valid <= 1'b0;
        win_now = (win == 8'd0) ? 1 : int'(win);
        seg_now = (seg == 16'd0) ? 1 : int'(seg);
        settings++;
    endtask

    // wait for every expected beat, then let a pending divide finish
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // start, then a well-formed mix of polls, acks and ticks with some broken headers
    task automatic run_transfer(input logic [31:0] len);
        int         r;
        int         span;
        logic [7:0] ackn;
        logic [7:0] rnd;
        burst_mode = ($urandom_range(0, 5) == 0);
        offer_beat(ACT_START, len, 8'd0, 1'b1);
        transfers++;
        for (int n = 0; n < 40 && tb_live; n++) begin
            span = int'(tb_next - tb_base);
            if (span < 1) span = 1;
            if (span > 255) span = 255;
            rnd = 8'($urandom);
            r   = $urandom_range(0, 99);
            if (r < 10)
                ackn = tb_base[7:0];
            else if (r < 85)
                ackn = tb_base[7:0] + 8'($urandom_range(1, span));
            else
                ackn = rnd;
            r = $urandom_range(0, 99);
            if (r < 40)
                offer_beat(ACT_POLL, 32'd0, ackn, 1'b1);
            else if (r < 70)
                offer_beat(ACT_ACK, 32'd0, ackn, 1'b1);
            else if (r < 88)
                offer_beat(ACT_TICK, 32'd0, ackn, 1'b1);
            else if (r < 96)
                offer_beat(ACT_ACK, 32'd0, ackn, 1'b0);
            else
                offer_beat(t_action'($urandom_range(0, 3)), $urandom, ackn,
                           $urandom_range(0, 1) == 1);
        end
    endtask

    // result side: random stall per beat, one long hold-off on request
    initial begin
        int stall;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                long_holds++;
            end
            stall = burst_mode ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    initial begin
        int          ph;
        logic [31:0] junk;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: window 1, segment 10240
        offer_beat(ACT_POLL, 32'd0, 8'd0, 1'b1);          // idle: no result
        offer_beat(ACT_ACK, 32'd0, 8'd1, 1'b1);           // idle ack ignored
        offer_beat(ACT_START, 32'd0, 8'd0, 1'b1);         // empty message, done at once
        offer_beat(ACT_START, 32'd20481, 8'd0, 1'b1);     // three segments, short tail
        offer_beat(ACT_POLL, 32'd0, 8'd0, 1'b1);
        offer_beat(ACT_POLL, 32'd0, 8'd0, 1'b1);          // window full
        offer_beat(ACT_ACK, 32'd0, 8'd1, 1'b0);           // corrupted header
        offer_beat(ACT_ACK, 32'd0, 8'd0, 1'b1);           // duplicate of base
        offer_beat(ACT_ACK, 32'd0, 8'd1, 1'b1);
        offer_beat(ACT_POLL, 32'd0, 8'd0, 1'b1);
        offer_beat(ACT_START, 32'd10240, 8'd0, 1'b1);     // restart while active
        offer_beat(ACT_POLL, 32'd0, 8'd0, 1'b1);          // single full last segment
        offer_beat(ACT_ACK, 32'd0, 8'd1, 1'b1);           // completes
        drain();

        configure(8'd4, 32'd2, 16'd100);
        offer_beat(ACT_START, 32'd250, 8'd0, 1'b1);
        repeat (4) offer_beat(ACT_POLL, 32'd0, 8'd0, 1'b1);
        repeat (3) offer_beat(ACT_TICK, 32'd0, 8'd0, 1'b1);   // third tick rewinds
        offer_beat(ACT_POLL, 32'd0, 8'd0, 1'b1);
        offer_beat(ACT_ACK, 32'd0, 8'd200, 1'b1);         // past the count, clamped
        drain();

        // zero window and zero segment size both behave as one
        configure(8'd0, 32'd1, 16'd0);
        junk = $urandom;
        write_reg(CFG_UNUSED, junk);
        cfg_valid <= 1'b0;
        offer_beat(ACT_START, 32'd3, 8'd0, 1'b1);
        offer_beat(ACT_POLL, 32'd0, 8'd0, 1'b1);
        offer_beat(ACT_POLL, 32'd0, 8'd0, 1'b1);
        drain();

        configure(8'd255, 32'hffff_ffff, 16'hffff);
        offer_beat(ACT_START, 32'hffff_ffff, 8'd0, 1'b1);
        repeat (2) offer_beat(ACT_POLL, 32'd0, 8'd0, 1'b1);
        offer_beat(ACT_ACK, 32'd0, 8'd255, 1'b1);
        offer_beat(ACT_POLL, 32'd0, 8'd0, 1'b1);
        drain();

        beats_live = 0;
        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: configure(8'd255, 32'd1, 16'd1);
                1: configure(8'd1, 32'hffff_ffff, 16'hffff);
                2: configure(8'd0, 32'($urandom_range(1, 6)), 16'd0);
                default: configure(($urandom_range(0, 3) == 0) ? 8'd255
                                                                : 8'($urandom_range(1, 16)),
                                   32'($urandom_range(1, 8)),
                                   16'($urandom_range(1, 2000)));
            endcase
            if (ph == 0) begin
                // polls pile up behind a stalled result port until the input backs off
                burst_mode = 1'b1;
                offer_beat(ACT_START, 32'd200, 8'd0, 1'b1);
                hold_req = 1'b1;
                repeat (40) offer_beat(ACT_POLL, 32'd0, 8'd0, 1'b1);
                burst_mode = 1'b0;
            end
            while (beats_live < (ph + 1) * BEATS_PER_PHASE)
                run_transfer(pick_length());
            drain();
        end

        $display("Covered %0d live input beats over %0d random transfers, %0d register settings.",
                 beats_live, transfers, settings);
        $display("Checked %0d result beats (%0d completions) with %0d long output stalls.",
                 checked, done_count, long_holds);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
